// ===== design/shmt_pkg.sv =====
// Package for the symbol histogram mode tracker.
// Holds the shared widths, opcodes, register indexes, memory control struct
// and the symbol fold table builder. It depends on nothing.
package shmt_pkg;

    localparam int DEF_ALPHABET_SIZE = 256;
    localparam int DEF_COUNT_WIDTH   = 16;

    localparam int SYMBOL_W    = 8;
    localparam int OUT_COUNT_W = 16;
    localparam int SCORE_W     = 17;
    localparam int DOC_W       = 16;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CHANGE = 1'b1;

    localparam logic REG_DOC_SIZE = 1'b0;

    localparam logic [SYMBOL_W-1:0] MODE_RESET = 8'd46;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    typedef logic [255:0][SYMBOL_W-1:0] t_fold_tab;

    function automatic t_fold_tab fold_table(int asize);
        t_fold_tab tab;
        int        c;
        c = 0;
        for (int i = 0; i < 256; i++) begin
            tab[i] = SYMBOL_W'(c);
            if (c == asize - 1) begin
                c = 0;
            end else begin
                c = c + 1;
            end
        end
        return tab;
    endfunction

endpackage

// ===== design/shmt_if.sv =====
// Handshake interfaces for the input items and result items of the tracker.
// Depends on shmt_pkg for the field widths.
interface shmt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [shmt_pkg::SYMBOL_W-1:0] old_symbol;
    logic [shmt_pkg::SYMBOL_W-1:0] new_symbol;

    modport source (output valid, opcode, old_symbol, new_symbol, input ready);
    modport sink (input valid, opcode, old_symbol, new_symbol, output ready);
endinterface

interface shmt_out_if;
    logic                                valid;
    logic                                ready;
    logic [shmt_pkg::OUT_COUNT_W-1:0]    mode_count;
    logic signed [shmt_pkg::SCORE_W-1:0] score;
    logic                                zero_count_error;

    modport source (output valid, mode_count, score, zero_count_error, input ready);
    modport sink (input valid, mode_count, score, zero_count_error, output ready);
endinterface

// ===== design/shmt_count_mem.sv =====
// Count memory of the tracker: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on shmt_pkg for the control struct.
module shmt_count_mem #(
    parameter int DEPTH  = shmt_pkg::DEF_ALPHABET_SIZE,
    parameter int ADDR_W = 8,
    parameter int DATA_W = shmt_pkg::DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shmt_pkg::t_mem_ctl i_ctl,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [DATA_W-1:0]  o_rd_data
);
    import shmt_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_valid;
    logic              same_addr;

    assign same_addr = i_ctl.we && (i_waddr == i_raddr);

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rd_data <= same_addr ? i_wdata : r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_rd_valid <= r_valid[i_raddr] || same_addr;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== design/shmt_cfg_regs.sv =====
// Configuration register file of the tracker on an APB-style port.
// Holds the document size register. Depends on shmt_pkg.
module shmt_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shmt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [shmt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [shmt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [shmt_pkg::DOC_W-1:0]        o_doc_size
);
    import shmt_pkg::*;

    logic [DOC_W-1:0] r_doc_size;
    logic             reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_size <= '0;
        end else if (wr_en && (reg_idx == REG_DOC_SIZE)) begin
            r_doc_size <= pwdata[DOC_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DOC_SIZE: prdata = CFG_DATA_W'(r_doc_size);
            default:      prdata = '0;
        endcase
    end

    assign o_doc_size = r_doc_size;

endmodule

// ===== design/symbol_histogram_mode_tracker_unit.sv =====
// Symbol histogram mode tracker: per-symbol counts with a running mode.
// Depends on shmt_pkg, shmt_if, shmt_count_mem and shmt_cfg_regs.
//
// Items arrive on i_item (valid/ready). An add item counts new_symbol once,
// a change item moves one occurrence from old_symbol to new_symbol. Each
// item yields one result on o_result with the mode count, the score against
// the document size and the zero count error flag.
// The user must write the document size register over the APB-style port
// at byte address 0 only while the block is idle; the block itself does not
// enforce this. pready is always high. An add item increments the count of
// new_symbol in S_RD_NEW; a change item decrements old_symbol in S_RD_OLD
// first, and a change to the same symbol goes straight to S_DONE. The result
// is loaded from S_DONE; the next item is accepted back in S_IDLE. When a
// change takes an occurrence from the mode symbol, the count memory is
// rescanned one entry per cycle in S_SCAN, as it has a single read port.
// Reset clears all counts at once through per-entry valid bits, sets the
// mode count to zero and the mode symbol to the full stop.
// A stalled receiver holds the result in the output register; the block
// still accepts one more item and holds its result until the register frees.
module symbol_histogram_mode_tracker_unit #(
    parameter int ALPHABET_SIZE = shmt_pkg::DEF_ALPHABET_SIZE,
    parameter int COUNT_WIDTH   = shmt_pkg::DEF_COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    shmt_in_if.sink                           i_item,
    shmt_out_if.source                        o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shmt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [shmt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [shmt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import shmt_pkg::*;

    localparam int SYM_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CMP_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
    localparam t_fold_tab FOLD_TAB = fold_table(ALPHABET_SIZE);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_SCAN,
        S_RD_NEW,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [SYM_W-1:0]            r_old, n_old;
    logic [SYM_W-1:0]            r_new, n_new;
    logic                        r_err, n_err;
    logic [COUNT_WIDTH-1:0]      r_highest, n_highest;
    logic [SYMBOL_W-1:0]         r_mode, n_mode;
    logic [SYM_W-1:0]            r_scan_idx, n_scan_idx;
    logic                        r_out_valid, n_out_valid;
    logic [OUT_COUNT_W-1:0]      r_out_count, n_out_count;
    logic signed [SCORE_W-1:0]   r_out_score, n_out_score;
    logic                        r_out_err, n_out_err;

    t_mem_ctl                    mem_ctl;
    logic [SYM_W-1:0]            mem_waddr;
    logic [COUNT_WIDTH-1:0]      mem_wdata;
    logic [SYM_W-1:0]            mem_raddr;
    logic [COUNT_WIDTH-1:0]      rd_data;
    logic [COUNT_WIDTH-1:0]      bumped;
    logic [DOC_W-1:0]            doc_size;
    logic [SYM_W-1:0]            in_old;
    logic [SYM_W-1:0]            in_new;
    logic                        out_free;
    logic [CMP_W-1:0]            high_ext;
    logic [CMP_W-1:0]            doc_ext;
    logic [SCORE_W-1:0]          diff;

    shmt_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_doc_size (doc_size)
    );

    shmt_count_mem #(
        .DEPTH  (ALPHABET_SIZE),
        .ADDR_W (SYM_W),
        .DATA_W (COUNT_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr   (mem_raddr),
        .o_rd_data (rd_data)
    );

    assign in_old   = FOLD_TAB[i_item.old_symbol][SYM_W-1:0];
    assign in_new   = FOLD_TAB[i_item.new_symbol][SYM_W-1:0];
    assign out_free = !r_out_valid || o_result.ready;
    assign bumped   = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;
    assign high_ext = CMP_W'(r_highest);
    assign doc_ext  = CMP_W'(doc_size);
    assign diff     = {1'b0, doc_size} - {1'b0, high_ext[OUT_COUNT_W-1:0]};

    assign i_item.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_old       = r_old;
        n_new       = r_new;
        n_err       = r_err;
        n_highest   = r_highest;
        n_mode      = r_mode;
        n_scan_idx  = r_scan_idx;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_count = r_out_count;
        n_out_score = r_out_score;
        n_out_err   = r_out_err;
        mem_ctl     = '0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_old = in_old;
                    n_new = in_new;
                    n_err = 1'b0;
                    if (i_item.opcode == OP_ADD) begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = in_new;
                        n_state    = S_RD_NEW;
                    end else if (in_old != in_new) begin
                        mem_ctl.re = 1'b1;
                        mem_raddr  = in_old;
                        n_state    = S_RD_OLD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD_OLD: begin
                mem_ctl.re = 1'b1;
                if (rd_data == '0) begin
                    n_err     = 1'b1;
                    mem_raddr = r_new;
                    n_state   = S_RD_NEW;
                end else begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = r_old;
                    mem_wdata  = rd_data - 1'b1;
                    if (SYMBOL_W'(r_old) == r_mode) begin
                        n_highest  = '0;
                        n_scan_idx = '0;
                        mem_raddr  = '0;
                        n_state    = S_SCAN;
                    end else begin
                        mem_raddr = r_new;
                        n_state   = S_RD_NEW;
                    end
                end
            end
            S_SCAN: begin
                mem_ctl.re = 1'b1;
                if (rd_data > r_highest) begin
                    n_highest = rd_data;
                    n_mode    = SYMBOL_W'(r_scan_idx);
                end
                if (r_scan_idx == LAST_SYM) begin
                    mem_raddr = r_new;
                    n_state   = S_RD_NEW;
                end else begin
                    mem_raddr  = r_scan_idx + 1'b1;
                    n_scan_idx = r_scan_idx + 1'b1;
                end
            end
            S_RD_NEW: begin
                mem_ctl.we = 1'b1;
                mem_waddr  = r_new;
                mem_wdata  = bumped;
                if (bumped > r_highest) begin
                    n_highest = bumped;
                    n_mode    = SYMBOL_W'(r_new);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_err;
                    n_out_count = (high_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                                : high_ext[OUT_COUNT_W-1:0];
                    n_out_score = (high_ext >= doc_ext) ? '0 : $signed(SCORE_W'(0) - diff);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_highest   <= '0;
            r_mode      <= MODE_RESET;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
            r_scan_idx  <= '0;
        end else begin
            r_state     <= n_state;
            r_highest   <= n_highest;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
            r_err       <= n_err;
            r_scan_idx  <= n_scan_idx;
        end
        r_old       <= n_old;
        r_new       <= n_new;
        r_out_count <= n_out_count;
        r_out_score <= n_out_score;
        r_out_err   <= n_out_err;
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.mode_count       = r_out_count;
    assign o_result.score            = r_out_score;
    assign o_result.zero_count_error = r_out_err;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state != S_IDLE))
        else $error("Accepted item did not start the sequencer.");

    a_done_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_result.valid && r_state == S_IDLE))
        else $error("Finished item was not loaded into the output register.");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_idx <= LAST_SYM))
        else $error("Rescan index ran past the alphabet.");

    a_scan_from_old: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && $past(r_state) != S_SCAN) |->
            ($past(r_state) == S_RD_OLD && r_scan_idx == '0 && r_highest == '0))
        else $error("Rescan started without a decrement of the mode symbol.");

    a_err_skips_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_OLD && rd_data == '0) |-> (!mem_ctl.we && n_state == S_RD_NEW))
        else $error("Zero count was decremented.");
`endif

endmodule
